// ----- rtl/spectrum_bar_peak_hold_core_defines.svh -----
// Assertion macros shared by the spectrum bar peak hold RTL.
`ifndef SPECTRUM_BAR_PEAK_HOLD_CORE_DEFINES_SVH
`define SPECTRUM_BAR_PEAK_HOLD_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset
`define SBPH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset
`define SBPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sbph_pkg.sv -----
// Shared types, widths and register codes of the spectrum bar peak hold block.
package sbph_pkg;

  // Field widths
  localparam int BIN_W     = 15;
  localparam int LEVEL_W   = 16;
  localparam int IDX_OUT_W = 6;
  localparam int ROWS_W    = 8;
  localparam int SCALE_W   = 14;
  localparam int DECAY_W   = 14;
  localparam int LOG_EXP_W = 4;
  // Integer part of log2 times scale after the Q8.8 and fraction shifts
  localparam int MAG_Q_W   = LOG_EXP_W + SCALE_W - 8;

  // Parameter defaults
  localparam int COLUMNS_DEF       = 64;
  localparam int LOG_FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAG_SCALE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BAR_DECAY  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_DECAY = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_EN    = 3'd4;

  // Reset values
  localparam logic [ROWS_W-1:0]  NUM_ROWS_RST   = 8'd12;
  localparam logic [SCALE_W-1:0] MAG_SCALE_RST  = 14'd480;
  localparam logic [DECAY_W-1:0] BAR_DECAY_RST  = 14'd451;
  localparam logic [DECAY_W-1:0] PEAK_DECAY_RST = 14'd41;
  localparam logic               PEAK_EN_RST    = 1'b1;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic [ROWS_W-1:0]  num_rows;
    logic [SCALE_W-1:0] mag_scale;
    logic [DECAY_W-1:0] bar_decay;
    logic [DECAY_W-1:0] peak_decay;
    logic               peak_en;
  } sbph_cfg_t;

endpackage

// ----- rtl/sbph_cfg_regs.sv -----
// APB register file for display height, log scale, decays and peak enable.
module sbph_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbph_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sbph_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sbph_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output sbph_pkg::sbph_cfg_t               cfg
);
  import sbph_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Register writes; addresses past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows   <= NUM_ROWS_RST;
      cfg.mag_scale  <= MAG_SCALE_RST;
      cfg.bar_decay  <= BAR_DECAY_RST;
      cfg.peak_decay <= PEAK_DECAY_RST;
      cfg.peak_en    <= PEAK_EN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUM_ROWS:   cfg.num_rows   <= pwdata[ROWS_W-1:0];
        REG_MAG_SCALE:  cfg.mag_scale  <= pwdata[SCALE_W-1:0];
        REG_BAR_DECAY:  cfg.bar_decay  <= pwdata[DECAY_W-1:0];
        REG_PEAK_DECAY: cfg.peak_decay <= pwdata[DECAY_W-1:0];
        REG_PEAK_EN:    cfg.peak_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_NUM_ROWS:   prdata = APB_DATA_W'(cfg.num_rows);
      REG_MAG_SCALE:  prdata = APB_DATA_W'(cfg.mag_scale);
      REG_BAR_DECAY:  prdata = APB_DATA_W'(cfg.bar_decay);
      REG_PEAK_DECAY: prdata = APB_DATA_W'(cfg.peak_decay);
      REG_PEAK_EN:    prdata = APB_DATA_W'(cfg.peak_en);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sbph_log2.sv -----
// Pipelined fixed-point log2: leading-one stage, then one squaring stage per fraction bit.
module sbph_log2 #(
  parameter int FRAC_BITS = sbph_pkg::LOG_FRAC_BITS_DEF,
  parameter int TAG_W     = 7
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [sbph_pkg::BIN_W-1:0]             value,
  input  logic [TAG_W-1:0]                       in_tag,
  output logic                                   out_valid,
  output logic [sbph_pkg::LOG_EXP_W+FRAC_BITS-1:0] log_val,
  output logic                                   out_zero,
  output logic [TAG_W-1:0]                       out_tag
);
  import sbph_pkg::*;

  localparam int MW = BIN_W;   // mantissa Q1.14

  logic [LOG_EXP_W-1:0] norm_exp;
  logic [MW-1:0]        norm_mant;

  logic                 vld_q  [0:FRAC_BITS];
  logic [MW-1:0]        mant_q [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_q [0:FRAC_BITS];
  logic [LOG_EXP_W-1:0] exp_q  [0:FRAC_BITS];
  logic                 zero_q [0:FRAC_BITS];
  logic [TAG_W-1:0]     tag_q  [0:FRAC_BITS];

  logic [2*MW-1:0]      sq_full [1:FRAC_BITS];
  logic [MW:0]          sq_top  [1:FRAC_BITS];
  logic [MW-1:0]        sq_mant [1:FRAC_BITS];
  logic                 sq_bit  [1:FRAC_BITS];

  // Leading one and normalisation to Q1.14
  always_comb begin
    norm_exp = '0;
    for (int i = 0; i < BIN_W; i++) begin
      if (value[i]) norm_exp = LOG_EXP_W'(i);
    end
    norm_mant = MW'(value << (LOG_EXP_W'(BIN_W - 1) - norm_exp));
  end

  // One squaring per stage; integer part of the square is the next fraction bit
  always_comb begin
    for (int k = 1; k <= FRAC_BITS; k++) begin
      sq_full[k] = (2*MW)'(mant_q[k-1]) * (2*MW)'(mant_q[k-1]);
      sq_top[k]  = sq_full[k][2*MW-1:MW-1];
      sq_bit[k]  = sq_top[k][MW];
      sq_mant[k] = sq_bit[k] ? sq_top[k][MW:1] : sq_top[k][MW-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FRAC_BITS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k <= FRAC_BITS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      mant_q[0] <= norm_mant;
      frac_q[0] <= '0;
      exp_q[0]  <= norm_exp;
      zero_q[0] <= (value == '0);
      tag_q[0]  <= in_tag;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        mant_q[k] <= sq_mant[k];
        frac_q[k] <= {frac_q[k-1][FRAC_BITS-2:0], sq_bit[k]};
        exp_q[k]  <= exp_q[k-1];
        zero_q[k] <= zero_q[k-1];
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign out_valid = vld_q[FRAC_BITS];
  assign log_val   = {exp_q[FRAC_BITS], frac_q[FRAC_BITS]};
  assign out_zero  = zero_q[FRAC_BITS];
  assign out_tag   = tag_q[FRAC_BITS];

endmodule

// ----- rtl/sbph_level_store.sv -----
// Per-bar level and peak memories with decay, raise to magnitude and write forwarding.
module sbph_level_store #(
  parameter int COLUMNS = sbph_pkg::COLUMNS_DEF,
  parameter int IW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [IW-1:0]                 rd_idx,
  input  logic                          cur_valid,
  input  logic [IW-1:0]                 cur_idx,
  input  logic [sbph_pkg::ROWS_W-1:0]   mag,
  input  sbph_pkg::sbph_cfg_t           cfg,
  output logic [sbph_pkg::LEVEL_W-1:0]  bar_lvl,
  output logic [sbph_pkg::LEVEL_W-1:0]  peak_lvl
);
  import sbph_pkg::*;

  logic [LEVEL_W-1:0] bar_mem  [0:COLUMNS-1];
  logic [LEVEL_W-1:0] peak_mem [0:COLUMNS-1];
  logic [COLUMNS-1:0] bar_vld;
  logic [COLUMNS-1:0] peak_vld;

  logic [LEVEL_W-1:0] rd_bar_q, rd_peak_q;
  logic               rd_bar_vld_q, rd_peak_vld_q;

  logic               fwd_valid_q;
  logic [IW-1:0]      fwd_idx_q;
  logic [LEVEL_W-1:0] fwd_bar_q, fwd_peak_q;

  logic               fwd_hit;
  logic [LEVEL_W-1:0] base_bar, base_peak, mag_q88;
  logic               wr_en;

  function automatic logic [LEVEL_W-1:0] decay_raise(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [DECAY_W-1:0] dec,
                                                      input logic [LEVEL_W-1:0] floor_lvl);
    logic [LEVEL_W-1:0] dec_ext;
    logic [LEVEL_W-1:0] dropped;
    dec_ext = LEVEL_W'(dec);
    dropped = (lvl > dec_ext) ? lvl - dec_ext : '0;
    return (floor_lvl > dropped) ? floor_lvl : dropped;
  endfunction

  assign wr_en = en && cur_valid;

  // Old value: the last word written wins over the memory read
  assign fwd_hit   = fwd_valid_q && (fwd_idx_q == cur_idx);
  assign base_bar  = fwd_hit ? fwd_bar_q  : (rd_bar_vld_q  ? rd_bar_q  : '0);
  assign base_peak = fwd_hit ? fwd_peak_q : (rd_peak_vld_q ? rd_peak_q : '0);
  assign mag_q88   = {mag, 8'h00};

  // Drop, clip at zero, lift to magnitude; peaks frozen when disabled
  assign bar_lvl  = decay_raise(base_bar, cfg.bar_decay, mag_q88);
  assign peak_lvl = cfg.peak_en ? decay_raise(base_peak, cfg.peak_decay, mag_q88)
                                : base_peak;

  // Entry valid bits stand in for clearing the memories at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_vld  <= '0;
      peak_vld <= '0;
    end else if (wr_en) begin
      bar_vld[cur_idx] <= 1'b1;
      if (cfg.peak_en) peak_vld[cur_idx] <= 1'b1;
    end
  end

  // Memory write and registered read, one bar ahead of use
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bar_mem[cur_idx] <= bar_lvl;
      if (cfg.peak_en) peak_mem[cur_idx] <= peak_lvl;
    end
    if (en) begin
      rd_bar_q      <= bar_mem[rd_idx];
      rd_peak_q     <= peak_mem[rd_idx];
      rd_bar_vld_q  <= bar_vld[rd_idx];
      rd_peak_vld_q <= peak_vld[rd_idx];
    end
  end

  // Forward register for read-after-write on back-to-back bars
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid_q <= 1'b0;
    end else if (en) begin
      fwd_valid_q <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx_q  <= cur_idx;
      fwd_bar_q  <= bar_lvl;
      fwd_peak_q <= peak_lvl;
    end
  end

endmodule

// ----- rtl/spectrum_bar_peak_hold_core.sv -----
// Spectrum bar falloff and peak hold: takes one bin word per cycle while bin_ready
// is high and returns one result word per finished bar, with no gaps in the stream.
// A bar result passes, after its last bin is accepted, through one input register,
// one leading-one stage and one squaring stage per log2 fraction bit, one scale
// multiply stage, and the output register. The bar and peak stores are COLUMNS-entry
// memories with a registered read issued from the log2 output ahead of the update,
// with a forward path for consecutive bars on the same entry; per-entry valid bits clear
// them at reset, so there is no clearing pass and bins are taken from the first
// cycle after reset. A two-word output buffer keeps input accepted while one
// result waits; bin_ready drops only when both output words are held.
module spectrum_bar_peak_hold_core #(
  parameter int COLUMNS       = sbph_pkg::COLUMNS_DEF,
  parameter int LOG_FRAC_BITS = sbph_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbph_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sbph_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sbph_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // bin stream
  input  logic                             bin_valid,
  output logic                             bin_ready,
  input  logic [sbph_pkg::BIN_W-1:0]       bin_level,
  input  logic                             bar_end,
  input  logic                             frame_end,
  // bar results
  output logic                             bar_valid,
  input  logic                             bar_ready,
  output logic [sbph_pkg::IDX_OUT_W-1:0]   bar_index,
  output logic [sbph_pkg::LEVEL_W-1:0]     bar_level,
  output logic [sbph_pkg::LEVEL_W-1:0]     peak_level,
  output logic                             last_bar
);
  import sbph_pkg::*;

  localparam int IW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int TAG_W = IW + 1;
  localparam int LW    = LOG_EXP_W + LOG_FRAC_BITS;
  localparam int PW    = LW + SCALE_W;

  sbph_cfg_t cfg;

  // pipeline enable and input side
  logic             en, bin_acc, bar_done;
  logic [BIN_W-1:0] bin_max;
  logic [BIN_W-1:0] running_max;
  logic [IW-1:0]    bar_counter;

  logic             s0_valid;
  logic [BIN_W-1:0] s0_max;
  logic [IW-1:0]    s0_idx;
  logic             s0_last;

  // log2 output
  logic             lg_valid, lg_zero;
  logic [LW-1:0]    lg_val;
  logic [TAG_W-1:0] lg_tag;

  // product stage
  logic             p_valid, p_zero, p_last;
  logic [PW-1:0]    p_prod;
  logic [IW-1:0]    p_idx;
  logic [MAG_Q_W-1:0] p_q;
  logic [ROWS_W-1:0]  mag;

  logic [LEVEL_W-1:0] new_bar, new_peak;

  // output register and skid word
  logic                 skid_valid;
  logic [IDX_OUT_W-1:0] skid_index;
  logic [LEVEL_W-1:0]   skid_bar, skid_peak;
  logic                 skid_last;
  logic                 push;

  sbph_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Whole pipeline moves unless the skid word is occupied
  assign en        = !skid_valid;
  assign bin_ready = en;
  assign bin_acc   = bin_valid && bin_ready;
  assign bar_done  = bar_end || frame_end;
  assign bin_max   = (bin_level > running_max) ? bin_level : running_max;

  // Running maximum and bar counter
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      bar_counter <= '0;
    end else if (bin_acc) begin
      if (bar_done) begin
        running_max <= '0;
        if (frame_end || bar_counter == IW'(COLUMNS - 1)) bar_counter <= '0;
        else bar_counter <= bar_counter + 1'b1;
      end else begin
        running_max <= bin_max;
      end
    end
  end

  // Input register: only finished bars go on
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= bin_acc && bar_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_max  <= bin_max;
      s0_idx  <= bar_counter;
      s0_last <= frame_end;
    end
  end

  sbph_log2 #(
    .FRAC_BITS (LOG_FRAC_BITS),
    .TAG_W     (TAG_W)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .value     (s0_max),
    .in_tag    ({s0_last, s0_idx}),
    .out_valid (lg_valid),
    .log_val   (lg_val),
    .out_zero  (lg_zero),
    .out_tag   (lg_tag)
  );

  // Scale multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= lg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= PW'(lg_val) * PW'(cfg.mag_scale);
      p_zero <= lg_zero;
      p_idx  <= lg_tag[IW-1:0];
      p_last <= lg_tag[IW];
    end
  end

  // Magnitude in rows, clamped to the display height
  assign p_q = p_prod[PW-1:LOG_FRAC_BITS+8];
  always_comb begin
    if (p_zero) mag = '0;
    else if (p_q > MAG_Q_W'(cfg.num_rows)) mag = cfg.num_rows;
    else mag = p_q[ROWS_W-1:0];
  end

  sbph_level_store #(
    .COLUMNS (COLUMNS),
    .IW      (IW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .rd_idx    (lg_tag[IW-1:0]),
    .cur_valid (p_valid),
    .cur_idx   (p_idx),
    .mag       (mag),
    .cfg       (cfg),
    .bar_lvl   (new_bar),
    .peak_lvl  (new_peak)
  );

  // Output register with one skid word behind it
  assign push = en && p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (bar_valid && bar_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        bar_valid <= push;
      end
    end else if (!bar_valid) begin
      bar_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bar_valid && bar_ready && skid_valid) begin
      bar_index  <= skid_index;
      bar_level  <= skid_bar;
      peak_level <= skid_peak;
      last_bar   <= skid_last;
    end else if (push && (!bar_valid || bar_ready)) begin
      bar_index  <= IDX_OUT_W'(p_idx);
      bar_level  <= new_bar;
      peak_level <= new_peak;
      last_bar   <= p_last;
    end
    if (push && bar_valid && !bar_ready) begin
      skid_index <= IDX_OUT_W'(p_idx);
      skid_bar   <= new_bar;
      skid_peak  <= new_peak;
      skid_last  <= p_last;
    end
  end

`include "spectrum_bar_peak_hold_core_defines.svh"

  `SBPH_ASSERT_NOW(a_skid_behind_out, skid_valid, bar_valid, "skid word held without an output word")
  `SBPH_ASSERT_NEXT(a_stall_fills_skid, bar_valid && !bar_ready && p_valid && !skid_valid, skid_valid, "stalled result not caught by skid")
  `SBPH_ASSERT_NEXT(a_max_cleared, bin_acc && bar_done, running_max == '0, "running maximum not cleared at bar end")
  `SBPH_ASSERT_NEXT(a_frame_wrap, bin_acc && frame_end, bar_counter == '0, "bar counter not returned to zero at frame end")

endmodule

// ----- tb/tb_spectrum_bar_peak_hold_core.sv -----
// Self-checking testbench of the spectrum bar peak hold core, with its own bar model.
module tb_spectrum_bar_peak_hold_core;
  import sbph_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int FRAC_BITS    = LOG_FRAC_BITS_DEF;
  localparam int LATENCY      = FRAC_BITS + 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_WORDS  = 24;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_mode_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [LEVEL_W-1:0]   bar;
    logic [LEVEL_W-1:0]   peak;
    logic                 last;
  } bar_word_t;

  // Bar model and queue of bar words still due from the core
  class bar_scoreboard;
    sbph_cfg_t          cfg;
    logic [LEVEL_W-1:0] bar_lvl[COLUMNS];
    logic [LEVEL_W-1:0] peak_lvl[COLUMNS];
    logic [BIN_W-1:0]   bin_max;
    int unsigned        bar_count;
    bar_word_t          due_bars[$];
    int                 errors;

    function new();
      cfg = '{NUM_ROWS_RST, MAG_SCALE_RST, BAR_DECAY_RST, PEAK_DECAY_RST, PEAK_EN_RST};
      foreach (bar_lvl[i]) begin
        bar_lvl[i]  = '0;
        peak_lvl[i] = '0;
      end
      bin_max   = '0;
      bar_count = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_NUM_ROWS:   cfg.num_rows   = value[ROWS_W-1:0];
        REG_MAG_SCALE:  cfg.mag_scale  = value[SCALE_W-1:0];
        REG_BAR_DECAY:  cfg.bar_decay  = value[DECAY_W-1:0];
        REG_PEAK_DECAY: cfg.peak_decay = value[DECAY_W-1:0];
        REG_PEAK_EN:    cfg.peak_en    = value[0];
        default: ;
      endcase
    endfunction

    // log2 with FRAC_BITS fraction bits: leading one, then squaring of a Q1.14 mantissa
    function int unsigned log2_fixed(logic [BIN_W-1:0] v);
      int unsigned e, m, frac;
      e    = 0;
      frac = 0;
      for (int i = 0; i < BIN_W; i++)
        if (v[i]) e = i;
      m = (32'(v) << (14 - e)) & 32'h7FFF;
      for (int i = 0; i < FRAC_BITS; i++) begin
        m    = (m * m) >> 14;
        frac = frac << 1;
        if (m >= 32'h8000) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      return (e << FRAC_BITS) | frac;
    endfunction

    // level drops by decay, saturating at zero, then is lifted to the magnitude
    function logic [LEVEL_W-1:0] drop_and_lift(int unsigned level, int unsigned decay,
                                               int unsigned lift);
      int unsigned v;
      v = level > decay ? level - decay : 0;
      return LEVEL_W'(lift > v ? lift : v);
    endfunction

    function void note_bin(logic [BIN_W-1:0] lvl, logic bend, logic fend);
      logic [BIN_W-1:0] mx;
      int unsigned      mag, scaled, idx;
      bar_word_t        w;
      mx = lvl > bin_max ? lvl : bin_max;
      if (!bend && !fend) begin
        bin_max = mx;
        return;
      end
      mag = 0;
      if (mx != 0) begin
        scaled = (log2_fixed(mx) * cfg.mag_scale) >> (FRAC_BITS + 8);
        mag    = scaled > cfg.num_rows ? cfg.num_rows : scaled;
      end
      idx = bar_count < COLUMNS ? bar_count : 0;
      bar_lvl[idx] = drop_and_lift(bar_lvl[idx], cfg.bar_decay, mag << 8);
      if (cfg.peak_en)
        peak_lvl[idx] = drop_and_lift(peak_lvl[idx], cfg.peak_decay, mag << 8);
      w.index = IDX_OUT_W'(idx);
      w.bar   = bar_lvl[idx];
      w.peak  = peak_lvl[idx];
      w.last  = fend;
      due_bars.push_back(w);
      bin_max   = '0;
      bar_count = (fend || idx + 1 >= COLUMNS) ? 0 : idx + 1;
    endfunction

    function void miss(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_bar(bar_word_t got);
      bar_word_t want;
      if (due_bars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected bar word: index %0d bar %0d peak %0d last %0d",
                   got.index, got.bar, got.peak, got.last);
        return;
      end
      want = due_bars.pop_front();
      if (got.index !== want.index) miss("bar_index", want.index, got.index);
      if (got.bar !== want.bar)     miss("bar_level", want.bar, got.bar);
      if (got.peak !== want.peak)   miss("peak_level", want.peak, got.peak);
      if (got.last !== want.last)   miss("last_bar", want.last, got.last);
    endfunction

    function int pending();
      return due_bars.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  bin_valid, bin_ready;
  logic [BIN_W-1:0]      bin_level;
  logic                  bar_end, frame_end;
  logic                  bar_valid, bar_ready;
  logic [IDX_OUT_W-1:0]  bar_index;
  logic [LEVEL_W-1:0]    bar_level, peak_level;
  logic                  last_bar;

  bar_scoreboard sb = new();
  flow_mode_t    flow = FLOW_FREE;
  int            cycles = 0;

  spectrum_bar_peak_hold_core i_dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .bin_valid, .bin_ready, .bin_level, .bar_end, .frame_end,
    .bar_valid, .bar_ready, .bar_index, .bar_level, .peak_level, .last_bar
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_pct(flow_mode_t m);
    return m == FLOW_SEND_IDLE ? 82 : m == FLOW_BOTH ? 26 : 0;
  endfunction

  function automatic int stall_pct(flow_mode_t m);
    return m == FLOW_RECV_STALL ? 82 : m == FLOW_BOTH ? 26 : 0;
  endfunction

  // Result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (!rst && bar_valid && bar_ready)
      sb.check_bar(bar_word_t'({bar_index, bar_level, peak_level, last_bar}));
    bar_ready <= ($urandom_range(99) >= stall_pct(flow));
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(int rows, int scale, int bdecay, int pdecay, int show);
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_MAG_SCALE, scale);
    write_reg(REG_BAR_DECAY, bdecay);
    write_reg(REG_PEAK_DECAY, pdecay);
    write_reg(REG_PEAK_EN, show);
  endtask

  // One bin word: optional idle cycles, then hold valid until taken
  task automatic send_bin(logic [BIN_W-1:0] lvl, logic bend, logic fend);
    while ($urandom_range(99) < gap_pct(flow)) begin
      bin_valid <= 1'b0;
      @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_level <= lvl;
    bar_end   <= bend;
    frame_end <= fend;
    do @(posedge clk); while (!bin_ready);
    sb.note_bin(lvl, bend, fend);
  endtask

  // Stop sending, wait for every due bar word, then let the pipe run dry
  task automatic settle_stream();
    bin_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Level spread over all exponents, zero included
  function automatic logic [BIN_W-1:0] rand_level();
    int e;
    e = $urandom_range(0, BIN_W);
    return e == 0 ? '0 : BIN_W'($urandom_range(0, (1 << e) - 1));
  endfunction

  function automatic int rand_decay();
    return $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 16383);
  endfunction

  // Mostly whole frames of bars with random content; some stray words
  task automatic run_frames(int words, bit long_first);
    int sent, nbars, nbins;
    bit first, closing, frame_last;
    sent  = 0;
    first = long_first;
    while (sent < words) begin
      if (!first && $urandom_range(99) < 15) begin
        send_bin(rand_level(), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        // long frames can run the bar counter past the last column
        nbars = (first || $urandom_range(11) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 8);
        for (int b = 0; b < nbars; b++) begin
          nbins = nbars > 8 ? $urandom_range(1, 2) : $urandom_range(1, 4);
          for (int k = 0; k < nbins; k++) begin
            closing    = (k == nbins - 1);
            frame_last = closing && (b == nbars - 1);
            // frame end sometimes comes without bar end
            send_bin(rand_level(), closing && !(frame_last && $urandom_range(3) == 0),
                     frame_last);
            sent++;
          end
        end
        first = 1'b0;
      end
      if ($urandom_range(19) == 0) settle_stream();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    bin_valid <= 1'b0;
    bin_level <= '0;
    bar_end   <= 1'b0;
    frame_end <= 1'b0;
    bar_ready <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings
    send_bin('0, 1'b1, 1'b0);           // empty bar, magnitude zero
    send_bin(15'h7FFF, 1'b1, 1'b0);     // largest bin
    send_bin(15'd1, 1'b1, 1'b0);        // log2 of one
    send_bin(15'h4000, 1'b1, 1'b0);     // power of two
    send_bin(15'd100, 1'b0, 1'b0);      // maximum held over several bins
    send_bin(15'd200, 1'b0, 1'b0);
    send_bin(15'd50, 1'b1, 1'b0);
    send_bin(15'd5000, 1'b0, 1'b1);     // frame end alone closes the bar
    send_bin(15'd12345, 1'b0, 1'b0);
    send_bin('0, 1'b1, 1'b0);
    send_bin(15'd3, 1'b1, 1'b1);
    send_bin('0, 1'b1, 1'b1);           // decay with nothing to lift it
    send_bin(15'h5555, 1'b0, 1'b0);
    send_bin(15'h2AAA, 1'b1, 1'b1);
    settle_stream();

    // Register settings and flow modes per phase
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: program_regs(255, 10200, 0, 0, 1);
        1: program_regs(2, 0, 16383, 16383, 0);
        2: program_regs(1, 16383, 16383, 0, 1);
        3: program_regs(0, 5000, 300, 20, 1);
        4: program_regs(200, 8000, 100, 10, 0);
        default: program_regs($urandom_range(2, 255), $urandom_range(0, 10200),
                              rand_decay(), rand_decay(), $urandom_range(0, 1));
      endcase
      flow = flow_mode_t'(p % 4);
      run_frames(PHASE_WORDS, p == 0);
      settle_stream();
    end

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
